// ===== sv/rpd_pkg.sv =====
`default_nettype none

package rpd_pkg;

    localparam int MAX_TRANSFER_BYTES = 16384;
    localparam int POS_W              = $clog2(MAX_TRANSFER_BYTES + 1);

    localparam logic [31:0] PACKET_MSG_TYPE = 32'd1;
    localparam logic [31:0] HEADER_BYTES    = 32'd44;
    localparam logic [31:0] DATA_BASE       = 32'd8;
    localparam logic [31:0] MAX_MSG_LEN     = 32'(MAX_TRANSFER_BYTES);

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_BAD_TYPE  = 2'd1,
        KIND_MALFORMED = 2'd2,
        KIND_TRUNCATED = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_transfer;
    } byte_item_t;

    typedef struct packed {
        kind_t      out_kind;
        logic [7:0] out_byte;
        logic       last_of_frame;
        logic       has_extras;
    } result_item_t;

endpackage

`default_nettype wire

// ===== sv/rndis_packet_deframer_top.sv =====
`default_nettype none

// channel   dir  handshake                   payload
// byte      in   byte_valid / byte_ready     byte_item_t   (in_byte, end_of_transfer)
// result    out  result_valid / result_ready result_item_t (kind, byte, last, extras)
//
// One byte per cycle unless result_ready stalls; a request yields at most one result.
// Path: input register, decode with message state, result register.
// The input register advances while the result register is empty or being drained.
// rst_n clears position, header words, extras and discard state; no sweep needed.

module rndis_packet_deframer_top
    import rpd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire byte_item_t   byte_data,
    input  wire logic         byte_valid,
    output logic              byte_ready,
    output result_item_t      result_data,
    output logic              result_valid,
    input  wire logic         result_ready
);

    byte_item_t   item;
    logic         item_valid;
    logic         slot_free;
    logic         advance;
    logic         res_valid;
    result_item_t res;

    assign advance = item_valid && slot_free;

    rpd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_data  (byte_data),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    rpd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    rpd_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_valid),
        .res          (res),
        .slot_free    (slot_free),
        .result_data  (result_data),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

`default_nettype wire

// ===== sv/rpd_in_stage.sv =====
`default_nettype none

module rpd_in_stage
    import rpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire byte_item_t byte_data,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire logic       advance,
    output byte_item_t      item,
    output logic            item_valid
);

    byte_item_t data_reg;
    logic       valid_reg;
    logic       valid_next;
    logic       take;

    assign byte_ready = !valid_reg || advance;
    assign take       = byte_valid && byte_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= byte_data;
        end
    end

    assign item       = data_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

// ===== sv/rpd_core.sv =====
`default_nettype none

module rpd_core
    import rpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire byte_item_t item,
    output logic            res_valid,
    output result_item_t    res
);

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [23:0]      type_reg,  type_next;
    logic [31:0]      mlen_reg,  mlen_next;
    logic [31:0]      off_reg,   off_next;
    logic [23:0]      dlen_reg,  dlen_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] end_reg,   end_next;
    logic             extras_reg, extras_next;
    logic             discard_reg, discard_next;

    logic [7:0]       b;
    logic             eot;
    logic             in_header;
    logic [1:0]       lane;
    logic [31:0]      type_full;
    logic [31:0]      dlen_full;
    logic [33:0]      msg_end;
    logic             bad_lengths;
    logic [POS_W:0]   pos_inc;
    logic             in_payload;
    logic             is_last;
    logic             payload_done;

    assign b         = item.in_byte;
    assign eot       = item.end_of_transfer;
    assign in_header = (pos_reg[POS_W-1:4] == '0);
    assign lane      = pos_reg[1:0];
    assign pos_inc   = {1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1};

    assign type_full = {b, type_reg};
    assign dlen_full = {b, dlen_reg};
    assign msg_end   = {2'b00, off_reg} + {2'b00, DATA_BASE} + {2'b00, dlen_full};
    assign bad_lengths = (mlen_reg < HEADER_BYTES) || (mlen_reg > MAX_MSG_LEN)
                       || (off_reg < DATA_BASE) || (msg_end > {2'b00, mlen_reg});

    assign in_payload   = (pos_reg >= start_reg) && (pos_reg < end_reg);
    assign is_last      = in_payload && (pos_inc == {1'b0, end_reg});
    assign payload_done = (pos_inc >= {1'b0, end_reg});

    always_comb
    begin
        pos_next     = pos_reg;
        type_next    = type_reg;
        mlen_next    = mlen_reg;
        off_next     = off_reg;
        dlen_next    = dlen_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        extras_next  = extras_reg;
        discard_next = discard_reg;
        res_valid    = 1'b0;
        res          = '{out_kind: KIND_PAYLOAD, out_byte: 8'd0,
                         last_of_frame: 1'b0, has_extras: 1'b0};

        if (discard_reg)
        begin
            if (eot)
            begin
                discard_next = 1'b0;
                pos_next     = '0;
                extras_next  = 1'b0;
            end
        end
        else if (in_header)
        begin
            case (pos_reg[3:2])
                2'd0:
                begin
                    if (lane != 2'd3)
                    begin
                        type_next[lane*8 +: 8] = b;
                    end
                end
                2'd1:    mlen_next[lane*8 +: 8] = b;
                2'd2:    off_next[lane*8 +: 8]  = b;
                default:
                begin
                    if (lane != 2'd3)
                    begin
                        dlen_next[lane*8 +: 8] = b;
                    end
                end
            endcase

            if (pos_reg == POS_W'(3) && type_full != PACKET_MSG_TYPE)
            begin
                res_valid    = 1'b1;
                res.out_kind = KIND_BAD_TYPE;
                pos_next     = '0;
                extras_next  = 1'b0;
                discard_next = !eot;
            end
            else if (pos_reg == POS_W'(15) && bad_lengths)
            begin
                res_valid    = 1'b1;
                res.out_kind = KIND_MALFORMED;
                pos_next     = '0;
                extras_next  = 1'b0;
                discard_next = !eot;
            end
            else if (eot)
            begin
                res_valid    = 1'b1;
                res.out_kind = KIND_TRUNCATED;
                pos_next     = '0;
                extras_next  = 1'b0;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
                if (pos_reg == POS_W'(15))
                begin
                    start_next = off_reg[POS_W-1:0] + DATA_BASE[POS_W-1:0];
                    end_next   = msg_end[POS_W-1:0];
                end
            end
        end
        else
        begin
            if (pos_reg < HEADER_BYTES[POS_W-1:0] && b != 8'd0)
            begin
                extras_next = 1'b1;
            end

            if (in_payload && (is_last || !eot))
            begin
                res_valid         = 1'b1;
                res.out_kind      = KIND_PAYLOAD;
                res.out_byte      = b;
                res.last_of_frame = is_last;
                res.has_extras    = is_last && extras_next;
            end
            else if (eot && !payload_done)
            begin
                res_valid    = 1'b1;
                res.out_kind = KIND_TRUNCATED;
                res.out_byte = in_payload ? b : 8'd0;
            end

            if (eot || pos_inc >= {1'b0, mlen_reg[POS_W-1:0]})
            begin
                pos_next    = '0;
                extras_next = 1'b0;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end

        if (!step)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            type_reg    <= '0;
            mlen_reg    <= '0;
            off_reg     <= '0;
            dlen_reg    <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            extras_reg  <= 1'b0;
            discard_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            type_reg    <= type_next;
            mlen_reg    <= mlen_next;
            off_reg     <= off_next;
            dlen_reg    <= dlen_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            extras_reg  <= extras_next;
            discard_reg <= discard_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rpd_out_stage.sv =====
`default_nettype none

module rpd_out_stage
    import rpd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire result_item_t res,
    output logic              slot_free,
    output result_item_t      result_data,
    output logic              result_valid,
    input  wire logic         result_ready
);

    result_item_t data_reg;
    logic         valid_reg;
    logic         valid_next;

    assign slot_free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result_data  = data_reg;
    assign result_valid = valid_reg;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench
    import rpd_pkg::*;
;

    typedef struct packed {
        byte_item_t   item;
        logic         typed;
        logic         has;
        result_item_t res;
    } script_row_t;

    localparam result_item_t NONE      = '0;
    localparam result_item_t TRUNC_0   = '{KIND_TRUNCATED, 8'h00, 1'b0, 1'b0};
    localparam result_item_t BAD_TYPE  = '{KIND_BAD_TYPE, 8'h00, 1'b0, 1'b0};
    localparam result_item_t MALFORMED = '{KIND_MALFORMED, 8'h00, 1'b0, 1'b0};
    localparam int SCRIPT_LEN = 22;

    // single-byte transfer, all-ones bad type, zero-length malformed header + discard
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{'{8'h00, 1'b1}, 1'b1, 1'b1, TRUNC_0},
        '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NONE},
        '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NONE},
        '{'{8'hFF, 1'b0}, 1'b1, 1'b0, NONE},
        '{'{8'hFF, 1'b1}, 1'b1, 1'b1, BAD_TYPE},
        '{'{8'h01, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b0, 1'b0, NONE},
        '{'{8'h00, 1'b0}, 1'b1, 1'b1, MALFORMED},
        '{'{8'hAA, 1'b1}, 1'b1, 1'b0, NONE}
    };

    logic         clk;
    logic         rst_n;
    byte_item_t   byte_data;
    logic         byte_valid;
    logic         byte_ready;
    result_item_t result_data;
    logic         result_valid;
    logic         result_ready;

    rndis_packet_deframer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_data    (byte_data),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .result_data  (result_data),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // deframer state as seen by the checker
    logic [POS_W-1:0] at_pos;
    logic [31:0]      word_type;
    logic [31:0]      word_len;
    logic [31:0]      word_off;
    logic [31:0]      word_dlen;
    bit               extras_nz;
    bit               dropping;
    bit               swallowed;

    result_item_t     deframed_due[$];
    logic [7:0]       xfer[$];
    bit               calm;
    int               mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic void start_message();
        at_pos = '0;
        extras_nz = 1'b0;
    endfunction

    function automatic bit deframe_byte(input byte_item_t it, output result_item_t res);
        logic [7:0]  b;
        logic        eot;
        logic [31:0] p;
        logic [1:0]  lane;
        logic [33:0] span;
        logic [31:0] first;
        logic [31:0] stop;
        bit          in_pl;
        bit          is_last;
        bit          done;
        bit          has;
        b = it.in_byte;
        eot = it.end_of_transfer;
        p = 32'(at_pos);
        lane = p[1:0];
        res = '0;
        has = 1'b0;
        swallowed = dropping;
        if (dropping)
        begin
            if (eot)
            begin
                dropping = 1'b0;
                start_message();
            end
            return 1'b0;
        end
        if (p < 4)
            word_type[lane*8 +: 8] = b;
        else if (p < 8)
            word_len[lane*8 +: 8] = b;
        else if (p < 12)
            word_off[lane*8 +: 8] = b;
        else if (p < 16)
            word_dlen[lane*8 +: 8] = b;
        else if (p < HEADER_BYTES && b != 8'h00)
            extras_nz = 1'b1;

        if (p == 3 && word_type != PACKET_MSG_TYPE)
        begin
            res.out_kind = KIND_BAD_TYPE;
            if (eot)
                start_message();
            else
                dropping = 1'b1;
            return 1'b1;
        end
        if (p == 15)
        begin
            span = 34'(word_off) + 34'(DATA_BASE) + 34'(word_dlen);
            if (word_len < HEADER_BYTES || word_len > MAX_MSG_LEN
                || word_off < DATA_BASE || span > 34'(word_len))
            begin
                res.out_kind = KIND_MALFORMED;
                if (eot)
                    start_message();
                else
                    dropping = 1'b1;
                return 1'b1;
            end
        end
        if (p < 16)
        begin
            if (eot)
            begin
                res.out_kind = KIND_TRUNCATED;
                has = 1'b1;
                start_message();
            end
            else
                at_pos = at_pos + 1'b1;
            return has;
        end

        first = word_off + DATA_BASE;
        stop = first + word_dlen;
        in_pl = p >= first && p < stop;
        is_last = in_pl && p + 1 == stop;
        done = p + 1 >= stop;
        if (in_pl && (is_last || !eot))
        begin
            res.out_kind = KIND_PAYLOAD;
            res.out_byte = b;
            res.last_of_frame = is_last;
            res.has_extras = is_last && extras_nz;
            has = 1'b1;
        end
        else if (eot && !done)
        begin
            res.out_kind = KIND_TRUNCATED;
            res.out_byte = in_pl ? b : 8'h00;
            has = 1'b1;
        end
        if (eot || p + 1 >= word_len)
            start_message();
        else
            at_pos = at_pos + 1'b1;
        return has;
    endfunction

    function automatic int pick_pause();
        if (calm)
            return 0;
        return $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
    endfunction

    // one request per call: hold until accepted, then optional idle
    task automatic feed_byte(input byte_item_t it, input bit typed, input bit typed_has,
                             input result_item_t typed_res);
        result_item_t guess;
        bit           has;
        int           pause;
        byte_data <= it;
        byte_valid <= 1'b1;
        @(negedge clk);
        while (!byte_ready)
            @(negedge clk);
        @(posedge clk);
        has = deframe_byte(it, guess);
        if (typed)
        begin
            has = typed_has;
            guess = typed_res;
        end
        if (has)
            deframed_due.push_back(guess);
        pause = pick_pause();
        if (pause > 0)
        begin
            byte_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (deframed_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic void build_transfer();
        logic [7:0]  hdr [16];
        logic [31:0] mtype;
        logic [31:0] len;
        logic [31:0] off;
        logic [31:0] dlen;
        int          n_msgs;
        int          body;
        int          flavor;
        int          keep;
        bit          stop;
        bit          noisy;
        xfer.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 24)) xfer.push_back(8'($urandom));
            return;
        end
        n_msgs = $urandom_range(1, 3);
        stop = 1'b0;
        for (int k = 0; k < n_msgs && !stop; k++)
        begin
            flavor = $urandom_range(0, 19);
            mtype = PACKET_MSG_TYPE;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(61, 200) : $urandom_range(44, 60);
            if ($urandom_range(0, 3) == 0)
                off = $urandom_range(8, 35);
            else
                off = $urandom_range(36, len - 8);
            if ($urandom_range(0, 4) == 0)
                dlen = 0;
            else if ($urandom_range(0, 4) == 0)
                dlen = len - off - 8;
            else
                dlen = $urandom_range(0, len - off - 8);
            body = len;
            case (flavor)
                0:
                begin
                    mtype = $urandom_range(0, 1) ? $urandom
                                                 : PACKET_MSG_TYPE | (32'h1 << $urandom_range(1, 31));
                    if (mtype == PACKET_MSG_TYPE)
                        mtype = 32'h0;
                    body = $urandom_range(4, 10);
                    stop = 1'b1;
                end
                1:
                begin
                    len = $urandom_range(0, 43);
                    body = 16 + $urandom_range(0, 6);
                    stop = 1'b1;
                end
                2:
                begin
                    len = $urandom_range(0, 1) ? MAX_MSG_LEN + 1 + $urandom_range(0, 1000)
                                               : 32'hFFFF_FFFF;
                    body = 16 + $urandom_range(0, 6);
                    stop = 1'b1;
                end
                3:
                begin
                    off = $urandom_range(0, 7);
                    body = 16 + $urandom_range(0, 6);
                    stop = 1'b1;
                end
                4:
                begin
                    dlen = $urandom_range(0, 1) ? len - off - 8 + $urandom_range(1, 8)
                                                : 32'hFFFF_FFFF - $urandom_range(0, 8);
                    body = 16 + $urandom_range(0, 6);
                    stop = 1'b1;
                end
                5:
                begin
                    // longest legal message, cut off near the payload
                    len = MAX_MSG_LEN;
                    off = 8 + $urandom_range(0, 40);
                    dlen = $urandom_range(0, 30);
                    body = off + 8 + dlen + $urandom_range(0, 6);
                    stop = 1'b1;
                end
                default: ;
            endcase
            for (int i = 0; i < 4; i++)
            begin
                hdr[i] = mtype[8*i +: 8];
                hdr[4+i] = len[8*i +: 8];
                hdr[8+i] = off[8*i +: 8];
                hdr[12+i] = dlen[8*i +: 8];
            end
            noisy = $urandom_range(0, 2) == 0;
            for (int i = 0; i < body; i++)
            begin
                if (i < 16)
                    xfer.push_back(hdr[i]);
                else if (i < 44)
                    xfer.push_back((noisy && $urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
                else
                    xfer.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 4) == 0)
        begin
            keep = $urandom_range(1, xfer.size());
            xfer = xfer[0:keep-1];
        end
    endfunction

    initial
    begin : stimulus
        byte_item_t it;
        int         rand_items;
        bit         paused;
        rst_n <= 1'b0;
        byte_valid <= 1'b0;
        byte_data <= '0;
        calm = 1'b0;
        mismatches = 0;
        at_pos = '0;
        word_type = '0;
        word_len = '0;
        word_off = '0;
        word_dlen = '0;
        extras_nz = 1'b0;
        dropping = 1'b0;
        swallowed = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < SCRIPT_LEN; r++)
            feed_byte(SCRIPT[r].item, SCRIPT[r].typed, SCRIPT[r].has, SCRIPT[r].res);
        drain_results();

        rand_items = 0;
        paused = 1'b0;
        while (rand_items < 650)
        begin
            build_transfer();
            calm = $urandom_range(0, 4) == 0;
            if (!paused && rand_items >= 300)
            begin
                paused = 1'b1;
                drain_results();
            end
            for (int i = 0; i < xfer.size(); i++)
            begin
                it.in_byte = xfer[i];
                it.end_of_transfer = (i == xfer.size() - 1);
                feed_byte(it, 1'b0, 1'b0, NONE);
                if (!swallowed)
                    rand_items++;
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (deframed_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", deframed_due.size()));
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    task automatic check_result(input result_item_t got);
        result_item_t want;
        if (deframed_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %0d/%02h/%b/%b", got.out_kind,
                                      got.out_byte, got.last_of_frame, got.has_extras));
            return;
        end
        want = deframed_due.pop_front();
        if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte
            || got.last_of_frame !== want.last_of_frame || got.has_extras !== want.has_extras)
            report_mismatch($sformatf("got %0d/%02h/%b/%b want %0d/%02h/%b/%b",
                                      got.out_kind, got.out_byte, got.last_of_frame,
                                      got.has_extras, want.out_kind, want.out_byte,
                                      want.last_of_frame, want.has_extras));
    endtask

    initial
    begin : receiver
        result_item_t seen;
        int           stall;
        result_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = pick_pause();
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(negedge clk);
            while (!result_valid)
                @(negedge clk);
            seen = result_data;
            @(posedge clk);
            check_result(seen);
        end
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/rpd_pkg.sv
sv/rpd_in_stage.sv
sv/rpd_core.sv
sv/rpd_out_stage.sv
sv/rndis_packet_deframer_top.sv
sim/testbench.sv
